// ===== sv/date_to_epoch_seconds_assert.svh =====
// Assertion macros for the date-to-epoch-seconds RTL.
`ifndef DATE_TO_EPOCH_SECONDS_ASSERT_SVH
`define DATE_TO_EPOCH_SECONDS_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define D2E_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define D2E_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/d2e_pkg.sv =====
// Shared widths, microcode word layout and tables for the date-to-epoch converter.
package d2e_pkg;

    localparam int unsigned DAY_W    = 5;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned YEAR_W   = 14;
    localparam int unsigned HOUR_W   = 5;
    localparam int unsigned MINUTE_W = 6;
    localparam int unsigned SECOND_W = 6;
    localparam int unsigned OUT_W    = 39;

    localparam int unsigned MUL_A_W  = 24;
    localparam int unsigned MUL_B_W  = 18;
    localparam int unsigned PROD_W   = MUL_A_W + MUL_B_W;
    localparam int unsigned Q100_W   = 7;
    localparam int unsigned DBM_W    = 9;
    localparam int unsigned STEP_W   = 4;

    localparam logic [YEAR_W-1:0]  YEAR_MIN  = YEAR_W'(1);
    localparam logic [YEAR_W-1:0]  YEAR_MAX  = YEAR_W'(9999);
    localparam logic [MONTH_W-1:0] MONTH_MIN = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] MONTH_MAX = MONTH_W'(12);
    localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);

    // floor(x/100) == (x*5243) >> 19 for every x below 43699
    localparam int unsigned RECIP100       = 5243;
    localparam int unsigned RECIP100_SHIFT = 19;
    localparam logic [Q100_W-1:0] REM_LAST = Q100_W'(99);

    // Day number of 1970-01-01 plus one, folding the day-of-month bias
    localparam logic signed [OUT_W-1:0] EPOCH_OFS = -OUT_W'(719163);

    localparam logic [STEP_W-1:0] STEP_FIRST     = STEP_W'(0);
    localparam logic [STEP_W-1:0] STEP_LEAP_SKIP = STEP_W'(8);
    localparam logic [STEP_W-1:0] STEP_LAST      = STEP_W'(14);

    typedef enum logic [2:0] {
        MA_PY,
        MA_Q100,
        MA_HOUR,
        MA_MINUTE,
        MA_ACC
    } t_ma;

    typedef enum logic [2:0] {
        MB_365,
        MB_RECIP100,
        MB_100,
        MB_86400,
        MB_3600,
        MB_60
    } t_mb;

    typedef enum logic [3:0] {
        AS_NONE,
        AS_PROD,
        AS_PY_DIV4,
        AS_Q100,
        AS_Q100_DIV4,
        AS_DBM,
        AS_ONE,
        AS_DAY,
        AS_EPOCH,
        AS_SECOND
    } t_as;

    typedef enum logic {
        JMP_NONE,
        JMP_NO_LEAP_DAY
    } t_jmp;

    typedef struct packed {
        t_ma               ma;
        t_mb               mb;
        logic              mul_en;
        t_as               add_src;
        logic              add_neg;
        logic              acc_clr;
        logic              q_ld;
        logic              rem_ld;
        t_jmp              jmp;
        logic [STEP_W-1:0] target;
        logic              last;
    } t_cword;

    typedef struct packed {
        logic   accept;
        logic   step_en;
        logic   out_ld;
        t_cword cw;
    } t_ctrl;

    typedef struct packed {
        logic no_leap_day;
    } t_dp_stat;

    // Days before the first of the month in a common year
    function automatic logic [DBM_W-1:0] days_before_month(input logic [MONTH_W-1:0] month);
        logic [DBM_W-1:0] d;
        case (month)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// ===== sv/d2e_ucode_rom.sv =====
// Microcode program store: one control word per sequencer step.
module d2e_ucode_rom (
    input  logic [d2e_pkg::STEP_W-1:0] i_step,
    output d2e_pkg::t_cword            o_cword
);

    always_comb begin
        o_cword         = '0;
        o_cword.ma      = d2e_pkg::MA_PY;
        o_cword.mb      = d2e_pkg::MB_365;
        o_cword.add_src = d2e_pkg::AS_NONE;
        o_cword.jmp     = d2e_pkg::JMP_NONE;
        o_cword.target  = d2e_pkg::STEP_FIRST;
        case (i_step)
            // prod = py*365
            4'd0: begin
                o_cword.ma     = d2e_pkg::MA_PY;
                o_cword.mb     = d2e_pkg::MB_365;
                o_cword.mul_en = 1'b1;
            end
            // acc = py*365; prod = py*recip(100)
            4'd1: begin
                o_cword.add_src = d2e_pkg::AS_PROD;
                o_cword.acc_clr = 1'b1;
                o_cword.ma      = d2e_pkg::MA_PY;
                o_cword.mb      = d2e_pkg::MB_RECIP100;
                o_cword.mul_en  = 1'b1;
            end
            // q100 = py/100; acc += py/4
            4'd2: begin
                o_cword.q_ld    = 1'b1;
                o_cword.add_src = d2e_pkg::AS_PY_DIV4;
            end
            // acc -= py/100; prod = q100*100
            4'd3: begin
                o_cword.add_src = d2e_pkg::AS_Q100;
                o_cword.add_neg = 1'b1;
                o_cword.ma      = d2e_pkg::MA_Q100;
                o_cword.mb      = d2e_pkg::MB_100;
                o_cword.mul_en  = 1'b1;
            end
            // acc += py/400
            4'd4: begin
                o_cword.add_src = d2e_pkg::AS_Q100_DIV4;
            end
            // rem = py%100; acc += days before month
            4'd5: begin
                o_cword.rem_ld  = 1'b1;
                o_cword.add_src = d2e_pkg::AS_DBM;
            end
            // skip the leap day unless past February of a leap year
            4'd6: begin
                o_cword.jmp    = d2e_pkg::JMP_NO_LEAP_DAY;
                o_cword.target = d2e_pkg::STEP_LEAP_SKIP;
            end
            4'd7: begin
                o_cword.add_src = d2e_pkg::AS_ONE;
            end
            4'd8: begin
                o_cword.add_src = d2e_pkg::AS_DAY;
            end
            4'd9: begin
                o_cword.add_src = d2e_pkg::AS_EPOCH;
            end
            // prod = days*86400
            4'd10: begin
                o_cword.ma     = d2e_pkg::MA_ACC;
                o_cword.mb     = d2e_pkg::MB_86400;
                o_cword.mul_en = 1'b1;
            end
            4'd11: begin
                o_cword.add_src = d2e_pkg::AS_PROD;
                o_cword.acc_clr = 1'b1;
                o_cword.ma      = d2e_pkg::MA_HOUR;
                o_cword.mb      = d2e_pkg::MB_3600;
                o_cword.mul_en  = 1'b1;
            end
            4'd12: begin
                o_cword.add_src = d2e_pkg::AS_PROD;
                o_cword.ma      = d2e_pkg::MA_MINUTE;
                o_cword.mb      = d2e_pkg::MB_60;
                o_cword.mul_en  = 1'b1;
            end
            4'd13: begin
                o_cword.add_src = d2e_pkg::AS_PROD;
            end
            4'd14: begin
                o_cword.add_src = d2e_pkg::AS_SECOND;
                o_cword.last    = 1'b1;
            end
            default: begin
                o_cword.last = 1'b1;
            end
        endcase
    end

endmodule

// ===== sv/d2e_datapath.sv =====
// Datapath: input capture with clamping, shared multiplier, accumulator, result register.
module d2e_datapath (
    input  logic                                 i_clk,
    input  d2e_pkg::t_ctrl                       i_ctrl,
    input  logic [d2e_pkg::DAY_W-1:0]            i_day,
    input  logic [d2e_pkg::MONTH_W-1:0]          i_month,
    input  logic [d2e_pkg::YEAR_W-1:0]           i_year,
    input  logic [d2e_pkg::HOUR_W-1:0]           i_hour,
    input  logic [d2e_pkg::MINUTE_W-1:0]         i_minute,
    input  logic [d2e_pkg::SECOND_W-1:0]         i_second,
    output d2e_pkg::t_dp_stat                    o_stat,
    output logic signed [d2e_pkg::OUT_W-1:0]     o_epoch_seconds
);

    localparam int unsigned MulAW = d2e_pkg::MUL_A_W;
    localparam int unsigned MulBW = d2e_pkg::MUL_B_W;
    localparam int unsigned OutW  = d2e_pkg::OUT_W;
    localparam int unsigned QW    = d2e_pkg::Q100_W;

    logic [d2e_pkg::DAY_W-1:0]      r_day;
    logic [d2e_pkg::MONTH_W-1:0]    r_month;
    logic [d2e_pkg::YEAR_W-1:0]     r_py;
    logic [d2e_pkg::HOUR_W-1:0]     r_hour;
    logic [d2e_pkg::MINUTE_W-1:0]   r_minute;
    logic [d2e_pkg::SECOND_W-1:0]   r_second;
    logic [QW-1:0]                  r_q100;
    logic [QW-1:0]                  r_rem;
    logic signed [d2e_pkg::PROD_W-1:0] r_prod;
    logic signed [OutW-1:0]         r_acc;
    logic signed [OutW-1:0]         r_out;

    logic [d2e_pkg::MONTH_W-1:0]    month_c;
    logic [d2e_pkg::YEAR_W-1:0]     year_c;
    logic signed [MulAW-1:0]        mul_a;
    logic signed [MulBW-1:0]        mul_b;
    logic signed [d2e_pkg::PROD_W-1:0] mul_p;
    logic signed [OutW-1:0]         add_op;
    logic signed [OutW-1:0]         acc_base;
    logic signed [OutW-1:0]         n_acc;

    d2e_pkg::t_cword cw;
    assign cw = i_ctrl.cw;

    // Clamp month and year into range at capture
    always_comb begin
        if (i_month < d2e_pkg::MONTH_MIN) begin
            month_c = d2e_pkg::MONTH_MIN;
        end else if (i_month > d2e_pkg::MONTH_MAX) begin
            month_c = d2e_pkg::MONTH_MAX;
        end else begin
            month_c = i_month;
        end
        if (i_year < d2e_pkg::YEAR_MIN) begin
            year_c = d2e_pkg::YEAR_MIN;
        end else if (i_year > d2e_pkg::YEAR_MAX) begin
            year_c = d2e_pkg::YEAR_MAX;
        end else begin
            year_c = i_year;
        end
    end

    always_comb begin
        unique case (cw.ma)
            d2e_pkg::MA_PY:     mul_a = MulAW'(r_py);
            d2e_pkg::MA_Q100:   mul_a = MulAW'(r_q100);
            d2e_pkg::MA_HOUR:   mul_a = MulAW'(r_hour);
            d2e_pkg::MA_MINUTE: mul_a = MulAW'(r_minute);
            d2e_pkg::MA_ACC:    mul_a = r_acc[MulAW-1:0];
            default:            mul_a = '0;
        endcase
        unique case (cw.mb)
            d2e_pkg::MB_365:      mul_b = MulBW'(365);
            d2e_pkg::MB_RECIP100: mul_b = MulBW'(d2e_pkg::RECIP100);
            d2e_pkg::MB_100:      mul_b = MulBW'(100);
            d2e_pkg::MB_86400:    mul_b = MulBW'(86400);
            d2e_pkg::MB_3600:     mul_b = MulBW'(3600);
            d2e_pkg::MB_60:       mul_b = MulBW'(60);
            default:              mul_b = '0;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_comb begin
        unique case (cw.add_src)
            d2e_pkg::AS_NONE:      add_op = '0;
            d2e_pkg::AS_PROD:      add_op = r_prod[OutW-1:0];
            d2e_pkg::AS_PY_DIV4:   add_op = OutW'(r_py >> 2);
            d2e_pkg::AS_Q100:      add_op = OutW'(r_q100);
            d2e_pkg::AS_Q100_DIV4: add_op = OutW'(r_q100 >> 2);
            d2e_pkg::AS_DBM:       add_op = OutW'(d2e_pkg::days_before_month(r_month));
            d2e_pkg::AS_ONE:       add_op = OutW'(1);
            d2e_pkg::AS_DAY:       add_op = OutW'(r_day);
            d2e_pkg::AS_EPOCH:     add_op = d2e_pkg::EPOCH_OFS;
            d2e_pkg::AS_SECOND:    add_op = OutW'(r_second);
            default:               add_op = '0;
        endcase
        acc_base = cw.acc_clr ? '0 : r_acc;
        n_acc    = cw.add_neg ? (acc_base - add_op) : (acc_base + add_op);
    end

    // py%4==3 means year%4==0; py%100==99 means year%100==0; add py/100%4==3 for year%400==0
    assign o_stat.no_leap_day = !((r_month > d2e_pkg::MONTH_FEB)
                                  && (r_py[1:0] == 2'b11)
                                  && ((r_rem != d2e_pkg::REM_LAST) || (r_q100[1:0] == 2'b11)));

    always_ff @(posedge i_clk) begin
        if (i_ctrl.accept) begin
            r_day    <= i_day;
            r_month  <= month_c;
            r_py     <= year_c - d2e_pkg::YEAR_W'(1);
            r_hour   <= i_hour;
            r_minute <= i_minute;
            r_second <= i_second;
        end
        if (i_ctrl.step_en) begin
            r_acc <= n_acc;
            if (cw.mul_en) begin
                r_prod <= mul_p;
            end
            if (cw.q_ld) begin
                r_q100 <= r_prod[d2e_pkg::RECIP100_SHIFT +: QW];
            end
            if (cw.rem_ld) begin
                // true remainder stays below 100, so 7 bits of the difference suffice
                r_rem <= r_py[QW-1:0] - r_prod[QW-1:0];
            end
        end
        if (i_ctrl.out_ld) begin
            r_out <= n_acc;
        end
    end

    assign o_epoch_seconds = r_out;

endmodule

// ===== sv/d2e_sequencer.sv =====
// Step counter, conditional jumps and both handshakes of the converter.
`include "date_to_epoch_seconds_assert.svh"

module d2e_sequencer (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    output logic                       o_valid,
    input  logic                       i_ready,
    input  d2e_pkg::t_cword            i_cword,
    input  d2e_pkg::t_dp_stat          i_stat,
    output logic [d2e_pkg::STEP_W-1:0] o_step,
    output d2e_pkg::t_ctrl             o_ctrl
);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state                      r_state;
    logic [d2e_pkg::STEP_W-1:0]  r_step;
    logic                        r_out_valid;

    logic                        in_acc;
    logic                        running;
    logic                        at_first;
    logic                        out_free;
    logic                        step_en;
    logic                        finish;
    logic                        take_jump;
    logic [d2e_pkg::STEP_W-1:0]  n_step;

    assign running  = (r_state == S_RUN);
    assign at_first = running && (r_step == d2e_pkg::STEP_FIRST);
    // take nothing while reset is held
    assign o_ready  = (r_state == S_IDLE) && i_rst_n;
    assign in_acc   = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;
    // hold the last step until the result register can take the transfer
    assign step_en  = running && (!i_cword.last || out_free);
    assign finish   = running && i_cword.last && out_free;

    assign take_jump = (i_cword.jmp == d2e_pkg::JMP_NO_LEAP_DAY) && i_stat.no_leap_day;
    assign n_step    = take_jump ? i_cword.target : (r_step + d2e_pkg::STEP_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= d2e_pkg::STEP_FIRST;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= S_RUN;
                        r_step  <= d2e_pkg::STEP_FIRST;
                    end
                end
                S_RUN: begin
                    if (finish) begin
                        r_state <= S_IDLE;
                    end else if (step_en) begin
                        r_step <= n_step;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_step         = r_step;
    assign o_ctrl.accept  = in_acc;
    assign o_ctrl.step_en = step_en;
    assign o_ctrl.out_ld  = finish;
    assign o_ctrl.cw      = i_cword;

    `D2E_ASSERT_NEXT(a_accept_starts, in_acc, at_first, "item did not start the program")
    `D2E_ASSERT_NOW(a_step_bound, running, r_step <= d2e_pkg::STEP_LAST, "step past program end")
    `D2E_ASSERT_NOW(a_finish_last, finish, r_step == d2e_pkg::STEP_LAST, "result loaded early")
    `D2E_ASSERT_NOW(a_valid_from_finish, $rose(r_out_valid), $past(finish), "valid without finish")

endmodule

// ===== sv/date_to_epoch_seconds.sv =====
// Top level: proleptic Gregorian date and time to signed seconds since 1970-01-01.
//
// One date (day, month, year, hour, minute, second) is taken per input transfer and
// one 39-bit two's complement count of seconds since 1970-01-01 00:00:00 comes back
// per output transfer. Month is clamped to 1..12 and year to 1..9999; day, hour,
// minute and second are counted arithmetically without range checks. A microcoded
// sequencer steps a 15-word program over one shared 24x18 multiplier and one
// accumulator, skipping the leap-day step when it does not apply; the block takes
// the next item in the cycle after the result is loaded. The last step holds while
// an earlier result still waits in the output register.
module date_to_epoch_seconds (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [d2e_pkg::DAY_W-1:0]            i_day,
    input  logic [d2e_pkg::MONTH_W-1:0]          i_month,
    input  logic [d2e_pkg::YEAR_W-1:0]           i_year,
    input  logic [d2e_pkg::HOUR_W-1:0]           i_hour,
    input  logic [d2e_pkg::MINUTE_W-1:0]         i_minute,
    input  logic [d2e_pkg::SECOND_W-1:0]         i_second,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [d2e_pkg::OUT_W-1:0]     o_epoch_seconds
);

    logic [d2e_pkg::STEP_W-1:0] step;
    d2e_pkg::t_cword            cword;
    d2e_pkg::t_ctrl             ctrl;
    d2e_pkg::t_dp_stat          stat;

    d2e_ucode_rom u_rom (
        .i_step  (step),
        .o_cword (cword)
    );

    d2e_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_cword (cword),
        .i_stat  (stat),
        .o_step  (step),
        .o_ctrl  (ctrl)
    );

    d2e_datapath u_dp (
        .i_clk           (i_clk),
        .i_ctrl          (ctrl),
        .i_day           (i_day),
        .i_month         (i_month),
        .i_year          (i_year),
        .i_hour          (i_hour),
        .i_minute        (i_minute),
        .i_second        (i_second),
        .o_stat          (stat),
        .o_epoch_seconds (o_epoch_seconds)
    );

endmodule
